// ===== sv/atoc_pkg.sv =====
`timescale 1ns / 1ps

package atoc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OpW     = 2;

  // Output tdata: result_value, status, padded to whole bytes
  localparam int unsigned OutW = ((ValueW + StatusW + 7) / 8) * 8;

  // Queue between the parser and the execution unit
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] CH_EQUALS = 8'd61;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'd48;
  localparam logic [ByteW-1:0] CH_NINE   = 8'd57;
  localparam logic [ByteW-1:0] CH_PLUS   = 8'd43;
  localparam logic [ByteW-1:0] CH_MINUS  = 8'd45;
  localparam logic [ByteW-1:0] CH_STAR   = 8'd42;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'd47;

  localparam logic [OpW-1:0] OP_ADD = 2'd0;
  localparam logic [OpW-1:0] OP_SUB = 2'd1;
  localparam logic [OpW-1:0] OP_MUL = 2'd2;
  localparam logic [OpW-1:0] OP_DIV = 2'd3;

  localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
  localparam logic [StatusW-1:0] STAT_DIV0   = 2'd1;
  localparam logic [StatusW-1:0] STAT_SYNTAX = 2'd2;

  // One parsed expression, ready to execute
  typedef struct packed {
    logic [ValueW-1:0] a;
    logic [ValueW-1:0] b;
    logic [OpW-1:0]    op;
    logic              bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/ascii_two_operand_calculator_unit.sv =====
`timescale 1ns / 1ps

// ASCII calculator: parses "A op B=" one received byte per item (A, B unsigned
// decimal, op one of + - * /) and emits one result per '=' with a 16-bit
// two's-complement value in tdata[15:0] and a status in tdata[17:16]
// (0 ok, 1 division by zero, 2 bad syntax; value is zero unless ok). The
// parser takes a byte every cycle; on '=' it hands the expression to a
// two-entry queue. The execution unit computes +, - and * straight into
// its output register and runs / as a load, 16 steps of a one-bit
// restoring divider and a write-back, taking no new expression meanwhile;
// input stalls only when the queue holds two expressions still waiting.

module ascii_two_operand_calculator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [atoc_pkg::ByteW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [atoc_pkg::OutW-1:0]   m_axis_tdata_o    // [15:0] result_value,
                                                        // [17:16] status, rest 0
);
  import atoc_pkg::*;

  logic                push;
  logic                pop;
  job_t                job_in;
  job_t                job_out;
  q_stat_t             q_stat;
  logic [ValueW-1:0]   out_value;
  logic [StatusW-1:0]  out_status;

  atoc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_i       (s_axis_tdata_i),
    .q_full_i     (q_stat.full),
    .byte_ready_o (s_axis_tready_o),
    .push_o       (push),
    .job_o        (job_in)
  );

  atoc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  atoc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .q_empty_i    (q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = {{(OutW - ValueW - StatusW){1'b0}}, out_status, out_value};

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("expression pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("execution unit popped an empty queue");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_status != STAT_OK)) |-> (out_value == '0))
    else $error("nonzero value with error status");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_status == STAT_OK || out_status == STAT_DIV0 ||
                         out_status == STAT_SYNTAX))
    else $error("illegal status code on output");
`endif

endmodule

// ===== sv/atoc_front.sv =====
`timescale 1ns / 1ps

module atoc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       byte_valid_i,
  input  logic [atoc_pkg::ByteW-1:0] byte_i,
  input  logic                       q_full_i,
  output logic                       byte_ready_o,
  output logic                       push_o,
  output atoc_pkg::job_t             job_o
);
  import atoc_pkg::*;

  logic [ValueW-1:0] first_q, first_d;
  logic [ValueW-1:0] second_q, second_d;
  logic [OpW-1:0]    op_q, op_d;
  logic              phase_q, phase_d;
  logic              err_q, err_d;
  logic [1:0]        seen_q, seen_d;

  logic              accept;
  logic              is_digit;
  logic              is_op;
  logic [OpW-1:0]    op_code;
  logic [3:0]        digit;
  logic [ValueW-1:0] fold_src;
  logic [ValueW-1:0] fold_val;

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = byte_i[3:0];

  // acc * 10 + digit, wrapped
  assign fold_src = phase_q ? second_q : first_q;
  assign fold_val = {fold_src[ValueW-4:0], 3'b000} + {fold_src[ValueW-2:0], 1'b0}
                  + {{(ValueW-4){1'b0}}, digit};

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_ADD;
    case (byte_i)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      CH_SLASH: op_code = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  assign job_o.a   = first_q;
  assign job_o.b   = second_q;
  assign job_o.op  = op_q;
  assign job_o.bad = err_q || !phase_q || (seen_q != 2'b11);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    op_d     = op_q;
    phase_d  = phase_q;
    err_d    = err_q;
    seen_d   = seen_q;
    push_o   = 1'b0;
    if (accept) begin
      if (is_digit) begin
        if (phase_q) begin
          second_d  = fold_val;
          seen_d[1] = 1'b1;
        end else begin
          first_d   = fold_val;
          seen_d[0] = 1'b1;
        end
      end else if (is_op) begin
        if (phase_q) begin
          err_d = 1'b1;
        end else begin
          op_d    = op_code;
          phase_d = 1'b1;
        end
      end else if (byte_i == CH_EQUALS) begin
        // hand the expression off and start over
        push_o   = 1'b1;
        first_d  = '0;
        second_d = '0;
        op_d     = OP_ADD;
        phase_d  = 1'b0;
        err_d    = 1'b0;
        seen_d   = '0;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      op_q     <= OP_ADD;
      phase_q  <= 1'b0;
      err_q    <= 1'b0;
      seen_q   <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      op_q     <= op_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      seen_q   <= seen_d;
    end
  end

endmodule

// ===== sv/atoc_queue.sv =====
`timescale 1ns / 1ps

module atoc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  atoc_pkg::job_t    job_i,
  input  logic              pop_i,
  output atoc_pkg::job_t    job_o,
  output atoc_pkg::q_stat_t stat_o
);
  import atoc_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/atoc_back.sv =====
`timescale 1ns / 1ps

module atoc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  atoc_pkg::job_t              job_i,
  input  logic                        q_empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [atoc_pkg::ValueW-1:0] out_value_o,
  output logic [atoc_pkg::StatusW-1:0] out_status_o
);
  import atoc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam int unsigned CntW   = $clog2(ValueW);

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ValueW-1:0]   quo_q, quo_d;
  logic [ValueW-1:0]   rem_q, rem_d;
  logic [ValueW-1:0]   dvs_q, dvs_d;
  logic                vld_q, vld_d;
  logic [ValueW-1:0]   val_q, val_d;
  logic [StatusW-1:0]  sts_q, sts_d;

  logic                out_free;
  logic [2*ValueW-1:0] product;
  logic [ValueW:0]     trial;
  logic [ValueW:0]     diff;

  assign out_free = !vld_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i && out_free;
  assign product  = job_i.a * job_i.b;

  // one restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_q, quo_q[ValueW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    vld_d   = vld_q && !out_ready_i;
    val_d   = val_q;
    sts_d   = sts_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (job_i.bad) begin
            vld_d = 1'b1;
            val_d = '0;
            sts_d = STAT_SYNTAX;
          end else begin
            case (job_i.op)
              OP_ADD: begin
                vld_d = 1'b1;
                val_d = job_i.a + job_i.b;
                sts_d = STAT_OK;
              end
              OP_SUB: begin
                vld_d = 1'b1;
                val_d = job_i.a - job_i.b;
                sts_d = STAT_OK;
              end
              OP_MUL: begin
                vld_d = 1'b1;
                val_d = product[ValueW-1:0];
                sts_d = STAT_OK;
              end
              default: begin
                if (job_i.b == '0) begin
                  vld_d = 1'b1;
                  val_d = '0;
                  sts_d = STAT_DIV0;
                end else begin
                  quo_d   = job_i.a;
                  rem_d   = '0;
                  dvs_d   = job_i.b;
                  cnt_d   = CntW'(ValueW - 1);
                  state_d = ST_DIV;
                end
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (!diff[ValueW]) begin
          rem_d = diff[ValueW-1:0];
          quo_d = {quo_q[ValueW-2:0], 1'b1};
        end else begin
          rem_d = trial[ValueW-1:0];
          quo_d = {quo_q[ValueW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the quotient until the output register frees up
        if (out_free) begin
          vld_d   = 1'b1;
          val_d   = quo_q;
          sts_d   = STAT_OK;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    val_q <= val_d;
    sts_q <= sts_d;
  end

  assign out_valid_o  = vld_q;
  assign out_value_o  = val_q;
  assign out_status_o = sts_q;

endmodule

// ===== verif/ascii_two_operand_calculator_checker.sv =====
`timescale 1ns / 1ps

module ascii_two_operand_calculator_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  input  logic [atoc_pkg::ByteW-1:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  input  logic [atoc_pkg::OutW-1:0]  m_axis_tdata_i,   // [15:0] result_value,
                                                       // [17:16] status
  output int                         fail_count_o,
  output int                         pending_count_o,
  output int                         result_count_o,
  output int                         div0_count_o,
  output int                         syntax_count_o
);

  import atoc_pkg::*;

  typedef struct packed {
    logic [ValueW-1:0] lhs;
    logic [ValueW-1:0] rhs;
    logic [OpW-1:0]    op;
    logic              rhs_phase;
    logic              malformed;
    logic [1:0]        digit_mask;  // bit 0: lhs has a digit, bit 1: rhs
  } expr_state_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
  } calc_result_t;

  expr_state_t  expr;
  calc_result_t expected_results[$];
  calc_result_t want;
  logic [ValueW-1:0]  got_value;
  logic [StatusW-1:0] got_status;
  int mismatches;
  int results_seen;
  int div0_seen;
  int syntax_seen;

  function automatic logic [ValueW-1:0] fold_decimal(logic [ValueW-1:0] acc,
                                                     logic [ByteW-1:0] digit);
    logic [31:0] wide;
    wide = 32'(acc) * 32'd10 + 32'(digit);
    return wide[ValueW-1:0];
  endfunction

  function automatic calc_result_t evaluate_expression(expr_state_t e);
    calc_result_t r;
    logic [31:0]  product;
    r.value  = '0;
    r.status = STAT_OK;
    if (e.malformed || !e.rhs_phase || e.digit_mask != 2'b11) begin
      r.status = STAT_SYNTAX;
    end else begin
      case (e.op)
        OP_ADD: r.value = e.lhs + e.rhs;
        OP_SUB: r.value = e.lhs - e.rhs;
        OP_MUL: begin
          product = 32'(e.lhs) * 32'(e.rhs);
          r.value = product[ValueW-1:0];
        end
        default: begin
          if (e.rhs == '0) r.status = STAT_DIV0;
          else r.value = e.lhs / e.rhs;
        end
      endcase
    end
    return r;
  endfunction

  // Advance the expression by one received byte; '=' yields a result.
  task automatic consume_rx_byte(input logic [ByteW-1:0] c);
    logic             is_op;
    logic [OpW-1:0]   op;
    calc_result_t     r;
    is_op = 1'b1;
    op    = OP_ADD;
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (expr.rhs_phase) begin
        expr.rhs = fold_decimal(expr.rhs, c - CH_ZERO);
        expr.digit_mask[1] = 1'b1;
      end else begin
        expr.lhs = fold_decimal(expr.lhs, c - CH_ZERO);
        expr.digit_mask[0] = 1'b1;
      end
    end else if (is_op) begin
      // keep the first operator, flag any later one
      if (expr.rhs_phase) begin
        expr.malformed = 1'b1;
      end else begin
        expr.op = op;
        expr.rhs_phase = 1'b1;
      end
    end else if (c == CH_EQUALS) begin
      r = evaluate_expression(expr);
      expected_results.push_back(r);
      if (r.status == STAT_DIV0) div0_seen++;
      if (r.status == STAT_SYNTAX) syntax_seen++;
      expr = '0;
    end else begin
      expr.malformed = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what, input calc_result_t exp_r,
                               input logic [ValueW-1:0] act_v,
                               input logic [StatusW-1:0] act_s);
    if (mismatches < 10) begin
      $display("[%0t] mismatch: %s, expected value %0d status %0d, got value %0d status %0d",
               $realtime, what, $signed(exp_r.value), exp_r.status, $signed(act_v), act_s);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expr = '0;
      expected_results.delete();
      mismatches = 0;
      results_seen = 0;
      div0_seen = 0;
      syntax_seen = 0;
      fail_count_o <= 0;
      pending_count_o <= 0;
      result_count_o <= 0;
      div0_count_o <= 0;
      syntax_count_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_value  = m_axis_tdata_i[ValueW-1:0];
        got_status = m_axis_tdata_i[ValueW +: StatusW];
        results_seen++;
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got_value, got_status);
        end else begin
          want = expected_results.pop_front();
          if (got_value !== want.value || got_status !== want.status) begin
            note_mismatch("wrong result", want, got_value, got_status);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) consume_rx_byte(s_axis_tdata_i);
      fail_count_o    <= mismatches;
      pending_count_o <= expected_results.size();
      result_count_o  <= results_seen;
      div0_count_o    <= div0_seen;
      syntax_count_o  <= syntax_seen;
    end
  end

endmodule

// ===== verif/ascii_two_operand_calculator_unit_tb.sv =====
`timescale 1ns / 1ps

module ascii_two_operand_calculator_unit_tb;

  import atoc_pkg::*;

  localparam int unsigned RunLimitNs = 2000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;    // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutW-1:0]      m_axis_tdata;         // [15:0] result_value, [17:16] status

  int fail_count;
  int pending_count;
  int result_count;
  int div0_count;
  int syntax_count;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  logic [ByteW-1:0] expr_bytes[$];

  always #2 clk_i = ~clk_i;

  ascii_two_operand_calculator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  ascii_two_operand_calculator_checker calc_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .result_count_o (result_count),
    .div0_count_o   (div0_count),
    .syntax_count_o (syntax_count)
  );

  // Result sink: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    #(RunLimitNs);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [ByteW-1:0] op_char(int k);
    case (k)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
  endfunction

  function automatic void add_digits(int n, bit zeros_only);
    repeat (n) expr_bytes.push_back(zeros_only ? CH_ZERO
                                               : CH_ZERO + ByteW'($urandom_range(9)));
  endfunction

  task automatic send_rx_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (expr_bytes[i]) send_rx_byte(expr_bytes[i]);
    expr_bytes.delete();
  endtask

  // Mostly well-formed expressions; some with one defect, some pure noise.
  task automatic send_expression();
    int dice;
    int kind;
    int a_digits;
    int b_digits;
    logic [ByteW-1:0] op_ch;
    dice = $urandom_range(99);
    if (dice >= 90) begin
      repeat ($urandom_range(1, 6)) expr_bytes.push_back(ByteW'($urandom_range(255)));
    end else begin
      op_ch    = op_char($urandom_range(3));
      a_digits = ($urandom_range(9) == 0) ? 6 : $urandom_range(1, 4);
      if (op_ch == CH_SLASH) b_digits = $urandom_range(1, 2);
      else b_digits = ($urandom_range(9) == 0) ? 6 : $urandom_range(1, 4);
      // defect kinds: stray byte, second operator, no lhs, no operator, no rhs
      kind = (dice < 80) ? 0 : $urandom_range(1, 5);
      if (kind != 3) add_digits(a_digits, 1'b0);
      if (kind != 4) expr_bytes.push_back(op_ch);
      if (kind == 2) expr_bytes.push_back(op_char($urandom_range(3)));
      if (kind != 5) add_digits(b_digits, op_ch == CH_SLASH && $urandom_range(5) == 0);
      if (kind == 1) begin
        expr_bytes.insert($urandom_range(expr_bytes.size()), ByteW'($urandom_range(255)));
      end
    end
    expr_bytes.push_back(CH_EQUALS);
    send_queued();
  endtask

  task automatic drain_results(input int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_bytes);
    int start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_expression();
    drain_results(40);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: digit extremes, division by zero, syntax errors of each kind
    add_text("0-9=");
    add_text("3*/4=");
    add_text("5/0=");
    add_text("8=");
    add_text("+2=");
    add_text("6*=");
    add_text("1");
    expr_bytes.push_back(8'h00);
    add_text("+2");
    expr_bytes.push_back(8'hFF);
    add_text("=");
    send_queued();
    drain_results(40);

    // hold the sink off while the source keeps pushing, to fill the block
    hold_asks++;
    repeat (30) send_expression();
    drain_results(40);

    run_phase(0, 0, 220);
    run_phase(68, 0, 260);
    run_phase(0, 68, 260);
    run_phase(6, 6, 260);
    drain_results(100);

    $display("summary: %0d bytes sent over four source/sink idle mixes with one long sink hold-off",
             bytes_sent);
    $display("summary: %0d results checked, %0d divisions by zero, %0d syntax errors",
             result_count, div0_count, syntax_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
